@@ src/tcce_pkg.sv @@
// Shared types and constants of the text console cursor engine.
// Holds geometry limits, field widths, command and state codes and the unit structs.
// No dependencies.
`timescale 1ns / 1ps

package tcce_pkg;

	// Screen geometry limits
	localparam int MAX_COLS  = 128;
	localparam int MAX_ROWS  = 64;
	localparam int COL_W     = $clog2(MAX_COLS);
	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int EFF_COL_W = $clog2(MAX_COLS + 1);
	localparam int EFF_ROW_W = $clog2(MAX_ROWS + 1);
	localparam int UNIT_W    = (EFF_COL_W > EFF_ROW_W) ? EFF_COL_W : EFF_ROW_W;

	// Field widths of the stream words
	localparam int CHAR_W     = 8;
	localparam int CMD_W      = 2;
	localparam int CELL_ROW_W = 6;
	localparam int CELL_COL_W = 7;
	localparam int GLYPH_W    = 8;
	localparam int M_DATA_W   = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int COLS_REG_W = 8;
	localparam int ROWS_REG_W = 7;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd2;

	localparam logic [COLS_REG_W-1:0] COLS_RESET = 8'd80;
	localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 7'd25;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
	localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
	localparam logic [CHAR_W-1:0] CH_BKSP    = 8'd8;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

	typedef enum logic [CMD_W-1:0] {
		CMD_DRAW   = 2'd0,
		CMD_SCROLL = 2'd1,
		CMD_CURSOR = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DRAW,
		ST_ROWADV,
		ST_CURSOR,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic                 enabled;
		logic [EFF_COL_W-1:0] eff_cols;
		logic [EFF_ROW_W-1:0] eff_rows;
	} cfg_t;

	typedef struct packed {
		logic              dec;
		logic [UNIT_W-1:0] operand;
		logic [UNIT_W-1:0] limit;
	} unit_req_t;

	typedef struct packed {
		logic [UNIT_W-1:0] result;
		logic              reach;
	} unit_rsp_t;

	typedef struct packed {
		cmd_t                  cmd;
		logic [CELL_ROW_W-1:0] row;
		logic [CELL_COL_W-1:0] col;
		logic [GLYPH_W-1:0]    glyph;
		logic                  last;
	} out_word_t;

endpackage

@@ src/tcce_step_unit.sv @@
// Shared step unit: increments or decrements a cursor coordinate and checks the bound.
// Used for column advance, row advance and backspace. Depends on tcce_pkg.
`timescale 1ns / 1ps

module tcce_step_unit (
	input  tcce_pkg::unit_req_t req,
	output tcce_pkg::unit_rsp_t rsp
);

	always_comb begin
		rsp.result = req.dec ? (req.operand - 1'b1) : (req.operand + 1'b1);
		rsp.reach  = (rsp.result >= req.limit);
	end

endmodule

@@ src/tcce_seq.sv @@
// Sequencer of the cursor engine: holds the cursor, steps one command per cycle while the output
// word register is not stalled, through the shared step unit, and drives that register. Depends on tcce_pkg.
`timescale 1ns / 1ps

module tcce_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tcce_pkg::cfg_t               cfg,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         req_type,
	input  logic [tcce_pkg::CHAR_W-1:0]  char_code,
	output logic                         out_valid,
	input  logic                         out_ready,
	output tcce_pkg::out_word_t          out_word,
	output tcce_pkg::unit_req_t          unit_req,
	input  tcce_pkg::unit_rsp_t          unit_rsp
);

	tcce_pkg::state_t                  state_q, state_d;
	logic [tcce_pkg::ROW_W-1:0]        row_q, row_d;
	logic [tcce_pkg::COL_W-1:0]        col_q, col_d;
	logic [tcce_pkg::GLYPH_W-1:0]      glyph_q;
	logic                              tab_q;
	logic                              out_valid_q;
	tcce_pkg::out_word_t               out_word_q, emit_word;
	logic                              emit;
	logic                              accept;
	logic                              step;
	logic                              printable;
	logic                              tab_fits;

	assign in_ready  = (state_q == tcce_pkg::ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign step      = !out_valid_q || out_ready;
	assign printable = (char_code >= tcce_pkg::CH_SPACE);
	assign tab_fits  = (tcce_pkg::UNIT_W'(col_q) < tcce_pkg::UNIT_W'(cfg.eff_cols));
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// Operand selection for the shared step unit
	always_comb begin
		unit_req.dec     = 1'b0;
		unit_req.operand = tcce_pkg::UNIT_W'(col_q);
		unit_req.limit   = tcce_pkg::UNIT_W'(cfg.eff_cols);
		case (state_q)
			tcce_pkg::ST_IDLE: begin
				unit_req.dec = 1'b1;
			end
			tcce_pkg::ST_ROWADV: begin
				unit_req.operand = tcce_pkg::UNIT_W'(row_q);
				unit_req.limit   = tcce_pkg::UNIT_W'(cfg.eff_rows);
			end
			default: begin
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tcce_pkg::ST_IDLE: begin
				if (accept) begin
					if (req_type) begin
						state_d = cfg.enabled ? tcce_pkg::ST_CLEAR : tcce_pkg::ST_IDLE;
					end else if (!cfg.enabled) begin
						state_d = tcce_pkg::ST_IDLE;
					end else if (char_code == tcce_pkg::CH_NEWLINE) begin
						state_d = tcce_pkg::ST_ROWADV;
					end else if (char_code == tcce_pkg::CH_RETURN ||
					             char_code == tcce_pkg::CH_BKSP) begin
						state_d = tcce_pkg::ST_CURSOR;
					end else if (char_code == tcce_pkg::CH_TAB) begin
						state_d = tab_fits ? tcce_pkg::ST_DRAW : tcce_pkg::ST_IDLE;
					end else if (printable) begin
						state_d = tcce_pkg::ST_DRAW;
					end
				end
			end
			tcce_pkg::ST_DRAW: begin
				if (step) begin
					// a tab keeps drawing until the column lands on a multiple of four or reaches the end of the row
					if (unit_rsp.reach) begin
						state_d = tcce_pkg::ST_ROWADV;
					end else if (tab_q && unit_rsp.result[1:0] != 2'b00) begin
						state_d = tcce_pkg::ST_DRAW;
					end else begin
						state_d = tcce_pkg::ST_CURSOR;
					end
				end
			end
			tcce_pkg::ST_ROWADV: begin
				if (step) begin
					state_d = tcce_pkg::ST_CURSOR;
				end
			end
			tcce_pkg::ST_CURSOR, tcce_pkg::ST_CLEAR: begin
				if (step) begin
					state_d = tcce_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tcce_pkg::ST_IDLE;
			end
		endcase
	end

	// Emitted word and cursor update
	always_comb begin
		emit            = 1'b0;
		emit_word.cmd   = tcce_pkg::CMD_DRAW;
		emit_word.row   = tcce_pkg::CELL_ROW_W'(row_q);
		emit_word.col   = tcce_pkg::CELL_COL_W'(col_q);
		emit_word.glyph = '0;
		emit_word.last  = 1'b0;
		row_d           = row_q;
		col_d           = col_q;
		case (state_q)
			tcce_pkg::ST_IDLE: begin
				if (accept) begin
					if (req_type) begin
						row_d = '0;
						col_d = '0;
					end else if (cfg.enabled) begin
						if (char_code == tcce_pkg::CH_NEWLINE ||
						    char_code == tcce_pkg::CH_RETURN) begin
							col_d = '0;
						end else if (char_code == tcce_pkg::CH_BKSP && col_q != '0) begin
							col_d = tcce_pkg::COL_W'(unit_rsp.result);
						end
					end
				end
			end
			tcce_pkg::ST_DRAW: begin
				if (step) begin
					emit            = 1'b1;
					emit_word.glyph = glyph_q;
					col_d           = unit_rsp.reach ? '0 : tcce_pkg::COL_W'(unit_rsp.result);
				end
			end
			tcce_pkg::ST_ROWADV: begin
				if (step) begin
					if (unit_rsp.reach) begin
						// clamp to the last row and scroll
						emit          = 1'b1;
						emit_word.cmd = tcce_pkg::CMD_SCROLL;
						emit_word.row = '0;
						emit_word.col = '0;
						row_d         = tcce_pkg::ROW_W'(cfg.eff_rows - 1'b1);
					end else begin
						row_d = tcce_pkg::ROW_W'(unit_rsp.result);
					end
				end
			end
			tcce_pkg::ST_CURSOR: begin
				if (step) begin
					emit           = 1'b1;
					emit_word.cmd  = tcce_pkg::CMD_CURSOR;
					emit_word.last = 1'b1;
				end
			end
			tcce_pkg::ST_CLEAR: begin
				if (step) begin
					emit           = 1'b1;
					emit_word.cmd  = tcce_pkg::CMD_CLEAR;
					emit_word.row  = '0;
					emit_word.col  = '0;
					emit_word.last = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcce_pkg::ST_IDLE;
			row_q       <= '0;
			col_q       <= '0;
			tab_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
			col_q   <= col_d;
			if (accept) begin
				tab_q <= (char_code == tcce_pkg::CH_TAB);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			glyph_q <= (char_code == tcce_pkg::CH_TAB) ? tcce_pkg::CH_SPACE : char_code;
		end
		if (emit) begin
			out_word_q <= emit_word;
		end
	end

endmodule

@@ src/text_console_cursor_engine_unit.sv @@
// After an item is accepted, its first result is loaded onto m_* by the state entered on acceptance
// (draw, row advance, cursor or clear); a newline that does not scroll emits nothing in row advance.
// An item runs from no result at all up to four tab spaces, a row advance and the cursor placement,
// one result per cycle through the shared step unit while m_tready is high. The next item is
// taken once the last result is loaded.
// Reset: arst_n clears cursor, sequencer and registers (enabled 0, 80 columns, 25 rows).
`timescale 1ns / 1ps

module text_console_cursor_engine_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [tcce_pkg::CHAR_W-1:0]    s_tdata,   // [7:0] char_code
	input  logic                           s_tuser,   // [0] req_type
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [tcce_pkg::M_DATA_W-1:0]  m_tdata,   // [5:0] cell_row, [12:6] cell_col,
	                                                  // [20:13] glyph_code, [23:21] zero
	output logic [tcce_pkg::CMD_W-1:0]     m_tuser,   // [1:0] command
	output logic                           m_tlast,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tcce_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tcce_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic                              enabled_q;
	logic [tcce_pkg::COLS_REG_W-1:0]   cols_q;
	logic [tcce_pkg::ROWS_REG_W-1:0]   rows_q;
	tcce_pkg::cfg_t                    cfg;
	tcce_pkg::unit_req_t               unit_req;
	tcce_pkg::unit_rsp_t               unit_rsp;
	tcce_pkg::out_word_t               out_word;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			cols_q    <= tcce_pkg::COLS_RESET;
			rows_q    <= tcce_pkg::ROWS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tcce_pkg::REG_ENABLED: enabled_q <= cfg_data[0];
				tcce_pkg::REG_COLS:    cols_q    <= cfg_data[tcce_pkg::COLS_REG_W-1:0];
				tcce_pkg::REG_ROWS:    rows_q    <= cfg_data[tcce_pkg::ROWS_REG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Clamp the screen size to 1..maximum
	always_comb begin
		cfg.enabled = enabled_q;
		if (cols_q == '0) begin
			cfg.eff_cols = tcce_pkg::EFF_COL_W'(1);
		end else if (32'(cols_q) > tcce_pkg::MAX_COLS) begin
			cfg.eff_cols = tcce_pkg::EFF_COL_W'(tcce_pkg::MAX_COLS);
		end else begin
			cfg.eff_cols = tcce_pkg::EFF_COL_W'(cols_q);
		end
		if (rows_q == '0) begin
			cfg.eff_rows = tcce_pkg::EFF_ROW_W'(1);
		end else if (32'(rows_q) > tcce_pkg::MAX_ROWS) begin
			cfg.eff_rows = tcce_pkg::EFF_ROW_W'(tcce_pkg::MAX_ROWS);
		end else begin
			cfg.eff_rows = tcce_pkg::EFF_ROW_W'(rows_q);
		end
	end

	tcce_step_unit u_step (
		.req (unit_req),
		.rsp (unit_rsp)
	);

	tcce_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.req_type  (s_tuser),
		.char_code (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_word  (out_word),
		.unit_req  (unit_req),
		.unit_rsp  (unit_rsp)
	);

	assign m_tdata = {3'b000, out_word.glyph, out_word.col, out_word.row};
	assign m_tuser = out_word.cmd;
	assign m_tlast = out_word.last;

endmodule

@@ src/tcce_checker.sv @@
// Port-level checker for the text console cursor engine, bound to the top level.
// Depends on tcce_pkg and text_console_cursor_engine_unit.
`timescale 1ns / 1ps

module tcce_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [tcce_pkg::M_DATA_W-1:0]  m_tdata,
	input logic [tcce_pkg::CMD_W-1:0]     m_tuser,
	input logic                           m_tlast
);

	// Hold a stalled word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
		$stable(m_tlast))
		else $error("output word changed while stalled");

	// A draw is always followed by a cursor placement, so never ends a request
	a_draw_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == tcce_pkg::CMD_DRAW |-> !m_tlast)
		else $error("draw word marked last");

	a_scroll_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == tcce_pkg::CMD_SCROLL |-> m_tdata == '0 && !m_tlast)
		else $error("malformed scroll word");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == tcce_pkg::CMD_CURSOR || m_tuser == tcce_pkg::CMD_CLEAR)
		|-> m_tlast)
		else $error("cursor or clear word not last");

endmodule

bind text_console_cursor_engine_unit tcce_checker u_tcce_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
